### design/kts_pkg.sv
// Shared types and constants for the keyed table with soft delete.
`default_nettype none
package kts_pkg;
	localparam int DefBuckets = 64;
	localparam int DefWays = 4;
	localparam int KeyW = 64;
	localparam int ValW = 32;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_GET    = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_PURGE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	typedef struct packed {
		logic load;
		logic hash;
		logic wr;
		logic purge;
		logic clear;
		logic done;
	} kts_cmd_t;
endpackage
`default_nettype wire

### design/kts_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none
module kts_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

### design/kts_ctrl.sv
// Controller state machine for the table commands, the purge sweep and the clearing pass.
`default_nettype none
module kts_ctrl import kts_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic [1:0] in_cmd,
	output logic      in_ready,
	input  wire logic out_busy,
	input  wire logic sweep_last,
	input  wire logic hash_last,
	output kts_cmd_t  ctl
);
	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_HASH, S_READ, S_EVAL, S_PREAD, S_PWRITE
	} state_t;
	state_t state_q;

	assign in_ready = (state_q == S_IDLE) && !out_busy;

	always_comb begin
		ctl = '0;
		ctl.load = in_ready && in_valid;
		ctl.hash = (state_q == S_HASH);
		ctl.wr = (state_q == S_EVAL) || (state_q == S_PWRITE) || (state_q == S_CLEAR);
		ctl.purge = (state_q == S_PREAD) || (state_q == S_PWRITE);
		ctl.clear = (state_q == S_CLEAR);
		ctl.done = (state_q == S_EVAL) || (state_q == S_PWRITE && sweep_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (sweep_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (ctl.load) begin
						state_q <= (cmd_t'(in_cmd) == CMD_PURGE) ? S_PREAD : S_HASH;
					end
				end
				S_HASH: begin
					if (hash_last) begin
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_EVAL;
				S_EVAL: state_q <= S_IDLE;
				S_PREAD: state_q <= S_PWRITE;
				S_PWRITE: state_q <= sweep_last ? S_IDLE : S_PREAD;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### design/kts_dp.sv
// Datapath: key to bucket reduction, bucket row storage, way compare, row update and result.
`default_nettype none
module kts_dp import kts_pkg::*; #(
	parameter int Buckets = DefBuckets,
	parameter int Ways = DefWays
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  kts_cmd_t             ctl,
	input  wire logic [1:0]      in_cmd,
	input  wire logic [KeyW-1:0] in_key,
	input  wire logic [ValW-1:0] in_val,
	output logic                 sweep_last,
	output logic                 hash_last,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [1:0]           out_status,
	output logic [ValW-1:0]      out_value
);
	localparam int AW = (Buckets > 1) ? $clog2(Buckets) : 1;
	localparam int RW = AW + 3;
	localparam int DataW = KeyW + ValW;
	localparam int VBit = DataW;
	localparam int DBit = DataW + 1;
	localparam int SlotW = DataW + 2;

	typedef logic [KeyW-1:0][RW-1:0] res_t;

	// Entry i holds 2**i modulo the bucket count.
	function automatic res_t res_init();
		res_t t;
		int r;
		r = 1 % Buckets;
		for (int i = 0; i < KeyW; i++) begin
			t[i] = RW'(r);
			r = (2 * r) % Buckets;
		end
		return t;
	endfunction

	localparam res_t Res = res_init();

	logic [1:0]      cmd_q;
	logic [KeyW-1:0] key_q;
	logic [ValW-1:0] val_q;
	logic [AW-1:0]   row_q;
	logic [3:0]      cnt_q;
	logic [RW-1:0]   acc_q;
	logic [RW-1:0]   sum;
	logic [RW-1:0]   acc_next;
	logic [Ways-1:0][SlotW-1:0] rdata;
	logic [Ways-1:0][SlotW-1:0] wdata;
	logic [Ways-1:0] we;
	logic [Ways-1:0] op_we;
	logic [Ways-1:0] hit;
	logic [Ways-1:0] hone;
	logic [Ways-1:0] fill;
	logic [Ways-1:0] rv;
	logic [Ways-1:0] rdl;
	logic            hfound;
	logic            ffound;
	logic            hdel;
	logic [ValW-1:0] hval;
	logic [SlotW-1:0] op_word;
	logic [1:0]      status;
	logic [ValW-1:0] rval;

	// Each step folds four key bits into the running residue, which stays below the bucket count.
	always_comb begin
		sum = acc_q;
		for (int b = 0; b < 4; b++) begin
			if (key_q[{cnt_q, 2'(b)}]) begin
				sum = sum + Res[{cnt_q, 2'(b)}];
			end
		end
		if (sum >= RW'(4 * Buckets)) begin
			acc_next = sum - RW'(4 * Buckets);
		end else if (sum >= RW'(3 * Buckets)) begin
			acc_next = sum - RW'(3 * Buckets);
		end else if (sum >= RW'(2 * Buckets)) begin
			acc_next = sum - RW'(2 * Buckets);
		end else if (sum >= RW'(Buckets)) begin
			acc_next = sum - RW'(Buckets);
		end else begin
			acc_next = sum;
		end
	end

	assign hash_last = (cnt_q == 4'd15);
	assign sweep_last = (row_q == AW'(Buckets - 1));

	always_comb begin
		hfound = 1'b0;
		ffound = 1'b0;
		hdel = 1'b0;
		hval = '0;
		hone = '0;
		fill = '0;
		for (int w = 0; w < Ways; w++) begin
			rv[w] = rdata[w][VBit];
			rdl[w] = rdata[w][DBit];
			hit[w] = rv[w] && (rdata[w][KeyW-1:0] == key_q);
			if (hit[w] && !hfound) begin
				hone[w] = 1'b1;
				hfound = 1'b1;
				hdel = rdl[w];
				hval = rdata[w][DataW-1:KeyW];
			end
			if (!rv[w] && !ffound) begin
				fill[w] = 1'b1;
				ffound = 1'b1;
			end
		end
	end

	always_comb begin
		status = ST_OK;
		rval = '0;
		op_we = '0;
		op_word = {1'b0, 1'b1, val_q, key_q};
		case (cmd_t'(cmd_q))
			CMD_INSERT: begin
				if (hfound) begin
					op_we = hone;
				end else if (ffound) begin
					op_we = fill;
				end else begin
					status = ST_FULL;
				end
			end
			CMD_GET: begin
				if (hfound && !hdel) begin
					rval = hval;
				end else begin
					status = ST_NOTFOUND;
				end
			end
			CMD_DELETE: begin
				op_word = {1'b1, 1'b1, hval, key_q};
				if (hfound) begin
					op_we = hone;
				end else begin
					status = ST_NOTFOUND;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int w = 0; w < Ways; w++) begin
			if (ctl.clear) begin
				wdata[w] = '0;
			end else if (ctl.purge) begin
				wdata[w] = {1'b0, rv[w] & ~rdl[w], rdata[w][DataW-1:0]};
			end else begin
				wdata[w] = op_word;
			end
		end
		if (!ctl.wr) begin
			we = '0;
		end else if (ctl.clear || ctl.purge) begin
			we = '1;
		end else begin
			we = op_we;
		end
	end

	for (genvar w = 0; w < Ways; w++) begin : g_way
		kts_ram #(.Width(SlotW), .Depth(Buckets > 1 ? Buckets : 2)) u_ram (
			.clk  (clk),
			.we   (we[w]),
			.addr ($clog2(Buckets > 1 ? Buckets : 2)'(row_q)),
			.wdata(wdata[w]),
			.rdata(rdata[w])
		);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= in_cmd;
			key_q <= in_key;
			val_q <= in_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			cnt_q <= '0;
			acc_q <= '0;
			out_valid <= 1'b0;
			out_status <= '0;
			out_value <= '0;
		end else begin
			if (ctl.load) begin
				row_q <= '0;
				cnt_q <= '0;
				acc_q <= '0;
			end else if (ctl.hash) begin
				cnt_q <= cnt_q + 4'd1;
				acc_q <= acc_next;
				if (hash_last) begin
					row_q <= AW'(acc_next);
				end
			end else if ((ctl.purge || ctl.clear) && ctl.wr && !sweep_last) begin
				row_q <= row_q + AW'(1);
			end
			if (ctl.done) begin
				out_valid <= 1'b1;
				out_status <= ctl.purge ? ST_OK : status;
				out_value <= ctl.purge ? '0 : rval;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

### design/keyed_table_soft_delete.sv
// Top level of the keyed table with soft delete and purge.
//  channel | direction | payload
//  s_axis  | in        | tdata: cmd, key, data_value
//  m_axis  | out       | tdata: status, read_value
// Insert, get and soft delete: the key is folded into its bucket four bits at a time, then the
// bucket row is read, then it is compared and written back, and the result is registered.
// Purge reads and writes back each row in turn, and its result is registered after the last
// row. After reset a clearing pass zeroes every row before the first request is taken. A
// result waits in the output register; the next request is accepted once it is taken.
`default_nettype none
module keyed_table_soft_delete import kts_pkg::*; #(
	parameter int BUCKETS = DefBuckets,
	parameter int WAYS = DefWays
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [103:0] s_axis_tdata,  // cmd[1:0], key[65:2], data_value[97:66]
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [39:0]       m_axis_tdata   // status[1:0], read_value[33:2]
);
	kts_cmd_t ctl;
	logic sweep_last;
	logic hash_last;
	logic [1:0] st;
	logic [ValW-1:0] rv;

	kts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_cmd(s_axis_tdata[1:0]),
		.in_ready(s_axis_tready), .out_busy(m_axis_tvalid),
		.sweep_last(sweep_last), .hash_last(hash_last), .ctl(ctl)
	);

	kts_dp #(.Buckets(BUCKETS), .Ways(WAYS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl),
		.in_cmd(s_axis_tdata[1:0]), .in_key(s_axis_tdata[65:2]),
		.in_val(s_axis_tdata[97:66]), .sweep_last(sweep_last),
		.hash_last(hash_last),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_status(st), .out_value(rv)
	);

	assign m_axis_tdata = {6'd0, rv, st};
endmodule
`default_nettype wire
